// ----- src/jrs_pkg.sv -----
// ----------------------------------------------------------------------------
// jrs_pkg
// Shared types and constants for the joystick rate to setpoint block.
// ----------------------------------------------------------------------------
package jrs_pkg;

  localparam int VAL_BITS   = 25;
  localparam int SCALE_BITS = 24;
  localparam int FRAC_BITS  = 16;
  localparam int OUT_W      = ((2 * VAL_BITS + 7) / 8) * 8;

  // apb register map
  localparam int ADDR_W    = 5;
  localparam int REG_IDX_W = 3;
  localparam int APB_W     = 32;

  // round(0.01 * 2^FRAC_BITS)
  localparam int STEP_HUNDREDTH = ((1 << FRAC_BITS) + 50) / 100;
  localparam int ROUND_BIAS     = 100;

  // divide by 200 as shift by 3 and divide by 25, radix 4
  localparam int DIV_SHIFT  = 3;
  localparam int DIV_BY     = 25;
  localparam int DIV_Y_BITS = VAL_BITS - DIV_SHIFT;
  localparam int DIV_STEPS  = (DIV_Y_BITS + 1) / 2;
  localparam int DIV_CNT_W  = $clog2(DIV_STEPS);
  localparam int REM_W      = $clog2(DIV_BY);
  localparam int PREM_W     = REM_W + 2;

  localparam logic signed [VAL_BITS-1:0] VAL_MAX = {1'b0, {(VAL_BITS-1){1'b1}}};
  localparam logic signed [VAL_BITS-1:0] VAL_MIN = {1'b1, {(VAL_BITS-1){1'b0}}};

  localparam logic signed [VAL_BITS-1:0] SP_LOW_RST  = -25'sd2949120;
  localparam logic signed [VAL_BITS-1:0] SP_HIGH_RST = 25'sd2949120;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_RAW_LOW    = 3'd0,
    REG_RAW_HIGH   = 3'd1,
    REG_RAW_CENTRE = 3'd2,
    REG_DEAD_ZONE  = 3'd3,
    REG_RATE_SCALE = 3'd4,
    REG_MOVE_THR   = 3'd5,
    REG_SP_LOW     = 3'd6,
    REG_SP_HIGH    = 3'd7
  } cfg_reg_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_FIN
  } state_e;

  typedef struct packed {
    logic                  start;
    logic [DIV_Y_BITS-1:0] dividend;
  } div_req_t;

  typedef struct packed {
    logic                  done;
    logic [DIV_Y_BITS-1:0] quotient;
  } div_rsp_t;

endpackage

// ----- src/jrs_div25.sv -----
// ----------------------------------------------------------------------------
// jrs_div25
// Digit-serial radix-4 divider by the constant 25, two dividend bits per cycle.
// ----------------------------------------------------------------------------
module jrs_div25 (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  jrs_pkg::div_req_t req_i,
  output jrs_pkg::div_rsp_t rsp_o
);
  import jrs_pkg::*;

  localparam int PAD_W = DIV_STEPS * 2;

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [PAD_W-1:0]     y_sh_q, y_sh_d;
  logic [REM_W-1:0]     rem_q, rem_d;
  logic [PAD_W-1:0]     quot_q, quot_d;
  logic [PREM_W-1:0]    part_rem;
  logic [1:0]           qdig;

  always_comb begin
    part_rem = {rem_q, y_sh_q[PAD_W-1 -: 2]};
    if (part_rem >= PREM_W'(3 * DIV_BY)) begin
      qdig = 2'd3;
    end else if (part_rem >= PREM_W'(2 * DIV_BY)) begin
      qdig = 2'd2;
    end else if (part_rem >= PREM_W'(DIV_BY)) begin
      qdig = 2'd1;
    end else begin
      qdig = 2'd0;
    end
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    y_sh_d = y_sh_q;
    rem_d  = rem_q;
    quot_d = quot_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = DIV_CNT_W'(DIV_STEPS - 1);
      y_sh_d = PAD_W'(req_i.dividend);
      rem_d  = '0;
      quot_d = '0;
    end else if (busy_q) begin
      y_sh_d = {y_sh_q[PAD_W-3:0], 2'b00};
      rem_d  = REM_W'(part_rem - PREM_W'(qdig) * PREM_W'(DIV_BY));
      quot_d = {quot_q[PAD_W-3:0], qdig};
      cnt_d  = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    y_sh_q <= y_sh_d;
    rem_q  <= rem_d;
    quot_q <= quot_d;
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quot_q[DIV_Y_BITS-1:0];

endmodule

// ----- src/joystick_rate_to_setpoint.sv -----
// ----------------------------------------------------------------------------
// joystick_rate_to_setpoint
// Deadband, rate scaling and setpoint integration for one joystick axis.
// ----------------------------------------------------------------------------
// each sample goes through the 4-bit serial multiplier and the 2-bit-per-cycle divide by 200;
// the next sample is taken only once the result of the last one is in the output register
// a finished result waits in the output register while the next sample is taken
// reset: registers return to defaults, setpoint cleared, no result pending
module joystick_rate_to_setpoint #(
  parameter int SAMPLE_BITS = 12
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // sample
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0] s_axis_tdata,
  // rate [24:0], position [49:25]
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [jrs_pkg::OUT_W-1:0]     m_axis_tdata,
  // configuration
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [jrs_pkg::ADDR_W-1:0]    paddr,
  input  logic [jrs_pkg::APB_W-1:0]     pwdata,
  output logic [jrs_pkg::APB_W-1:0]     prdata,
  output logic                          pready
);
  import jrs_pkg::*;

  localparam int NDIG   = (SAMPLE_BITS + 3) / 4;
  localparam int MAG_W  = NDIG * 4;
  localparam int PROD_W = SCALE_BITS + MAG_W;
  localparam int DCNT_W = (NDIG > 1) ? $clog2(NDIG) : 1;
  localparam int CMP_W  = SAMPLE_BITS + 2;
  localparam logic [SAMPLE_BITS-1:0] RAW_HIGH_RST   = SAMPLE_BITS'(4095);
  localparam logic [SAMPLE_BITS-1:0] RAW_CENTRE_RST = SAMPLE_BITS'(2048);

  // configuration registers
  logic [SAMPLE_BITS-1:0]       raw_low_q, raw_high_q, raw_centre_q, dead_zone_q;
  logic [SCALE_BITS-1:0]        rate_scale_q, move_thr_q;
  logic signed [VAL_BITS-1:0]   sp_low_q, sp_high_q;
  logic                         cfg_wr;
  cfg_reg_e                     cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign cfg_idx = cfg_reg_e'(paddr[ADDR_W-1:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      raw_low_q    <= '0;
      raw_high_q   <= RAW_HIGH_RST;
      raw_centre_q <= RAW_CENTRE_RST;
      dead_zone_q  <= '0;
      rate_scale_q <= SCALE_BITS'(1 << FRAC_BITS);
      move_thr_q   <= '0;
      sp_low_q     <= SP_LOW_RST;
      sp_high_q    <= SP_HIGH_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_RAW_LOW:    raw_low_q    <= pwdata[SAMPLE_BITS-1:0];
        REG_RAW_HIGH:   raw_high_q   <= pwdata[SAMPLE_BITS-1:0];
        REG_RAW_CENTRE: raw_centre_q <= pwdata[SAMPLE_BITS-1:0];
        REG_DEAD_ZONE:  dead_zone_q  <= pwdata[SAMPLE_BITS-1:0];
        REG_RATE_SCALE: rate_scale_q <= pwdata[SCALE_BITS-1:0];
        REG_MOVE_THR:   move_thr_q   <= pwdata[SCALE_BITS-1:0];
        REG_SP_LOW:     sp_low_q     <= pwdata[VAL_BITS-1:0];
        REG_SP_HIGH:    sp_high_q    <= pwdata[VAL_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_RAW_LOW:    prdata = APB_W'(raw_low_q);
      REG_RAW_HIGH:   prdata = APB_W'(raw_high_q);
      REG_RAW_CENTRE: prdata = APB_W'(raw_centre_q);
      REG_DEAD_ZONE:  prdata = APB_W'(dead_zone_q);
      REG_RATE_SCALE: prdata = APB_W'(rate_scale_q);
      REG_MOVE_THR:   prdata = APB_W'(move_thr_q);
      REG_SP_LOW:     prdata = {{(APB_W-VAL_BITS){sp_low_q[VAL_BITS-1]}}, sp_low_q};
      REG_SP_HIGH:    prdata = {{(APB_W-VAL_BITS){sp_high_q[VAL_BITS-1]}}, sp_high_q};
      default:        prdata = '0;
    endcase
  end

  // window, deadband and deflection of the incoming sample
  logic [SAMPLE_BITS-1:0]  sample;
  logic signed [CMP_W-1:0] s_x, c_x, band_hi, band_lo, diff;
  logic                    in_window, outside_band, active, diff_neg;
  logic [SAMPLE_BITS-1:0]  diff_mag;

  always_comb begin
    sample       = s_axis_tdata[SAMPLE_BITS-1:0];
    s_x          = signed'({2'b00, sample});
    c_x          = signed'({2'b00, raw_centre_q});
    band_hi      = c_x + signed'({2'b00, dead_zone_q});
    band_lo      = c_x - signed'({2'b00, dead_zone_q});
    diff         = s_x - c_x;
    in_window    = (sample >= raw_low_q) && (sample <= raw_high_q);
    outside_band = (s_x > band_hi) || (s_x < band_lo);
    active       = in_window && outside_band;
    diff_neg     = diff[CMP_W-1];
    diff_mag     = diff_neg ? SAMPLE_BITS'(-diff) : SAMPLE_BITS'(diff);
  end

  // control
  state_e state_q, state_d;
  logic   in_take, mul_last, out_free, out_load;
  logic   div_start_q;
  logic [DCNT_W-1:0] dig_cnt_q;
  div_req_t div_req;
  div_rsp_t div_rsp;

  assign in_take  = s_axis_tvalid & s_axis_tready;
  assign mul_last = (dig_cnt_q == '0);
  assign out_free = ~m_axis_tvalid | m_axis_tready;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (s_axis_tvalid) state_d = ST_MUL;
      ST_MUL:  if (mul_last) state_d = ST_DIV;
      ST_DIV:  if (div_rsp.done) state_d = ST_FIN;
      ST_FIN:  if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready = 1'b0;
    out_load      = 1'b0;
    unique case (state_q)
      ST_IDLE: s_axis_tready = 1'b1;
      ST_FIN:  out_load = out_free;
      default: ;
    endcase
  end

  // serial multiply, one 4-bit digit of the deflection per cycle
  logic [MAG_W-1:0]  mag_sh_q;
  logic [PROD_W-1:0] prod_q, pp;
  logic              neg_q;

  assign pp = PROD_W'(rate_scale_q) * PROD_W'(mag_sh_q[MAG_W-1 -: 4]);

  // saturation of the product and the rounded divide input
  logic [VAL_BITS-1:0]        sat_lim, mag_sat, div_x;
  logic signed [VAL_BITS-1:0] rate_val;
  logic                       up_val, dn_val;

  always_comb begin
    sat_lim  = neg_q ? (VAL_BITS'(1) << (VAL_BITS - 1)) : VAL_BITS'(VAL_MAX);
    mag_sat  = (prod_q > PROD_W'(sat_lim)) ? sat_lim : prod_q[VAL_BITS-1:0];
    rate_val = neg_q ? signed'(-mag_sat) : signed'(mag_sat);
    up_val   = ~neg_q & (mag_sat > VAL_BITS'(move_thr_q));
    dn_val   = neg_q & (mag_sat > VAL_BITS'(move_thr_q));
    div_x    = mag_sat + VAL_BITS'(ROUND_BIAS);
  end

  // divider starts once the last digit is in the product
  assign div_req.start    = div_start_q;
  assign div_req.dividend = div_x[VAL_BITS-1:DIV_SHIFT];

  jrs_div25 u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // setpoint step and saturation
  logic signed [VAL_BITS-1:0] rate_q, setpoint_q, sp_next;
  logic                       up_q, dn_q;
  logic signed [VAL_BITS+1:0] step, sum;

  always_comb begin
    step = signed'((VAL_BITS+2)'(STEP_HUNDREDTH) + (VAL_BITS+2)'(div_rsp.quotient));
    sum  = (VAL_BITS+2)'(setpoint_q);
    if (dn_q && (setpoint_q >= sp_low_q)) begin
      sum = (VAL_BITS+2)'(setpoint_q) - step;
    end else if (up_q && (setpoint_q <= sp_high_q)) begin
      sum = (VAL_BITS+2)'(setpoint_q) + step;
    end
    if (sum > (VAL_BITS+2)'(VAL_MAX)) begin
      sp_next = VAL_MAX;
    end else if (sum < (VAL_BITS+2)'(VAL_MIN)) begin
      sp_next = VAL_MIN;
    end else begin
      sp_next = sum[VAL_BITS-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      dig_cnt_q     <= '0;
      div_start_q   <= 1'b0;
      setpoint_q    <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      state_q     <= state_d;
      div_start_q <= (state_q == ST_MUL) && mul_last;
      if (in_take) begin
        dig_cnt_q <= DCNT_W'(NDIG - 1);
      end else if (state_q == ST_MUL) begin
        dig_cnt_q <= dig_cnt_q - 1'b1;
      end
      if (out_load) begin
        setpoint_q    <= sp_next;
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      mag_sh_q <= active ? MAG_W'(diff_mag) : '0;
      neg_q    <= active & diff_neg;
      prod_q   <= '0;
    end else if (state_q == ST_MUL) begin
      mag_sh_q <= {mag_sh_q[MAG_W-5:0], 4'b0000};
      prod_q   <= {prod_q[PROD_W-5:0], 4'b0000} + pp;
    end
    if (state_q == ST_DIV) begin
      rate_q <= rate_val;
      up_q   <= up_val;
      dn_q   <= dn_val;
    end
    if (out_load) begin
      m_axis_tdata <= {(OUT_W - 2 * VAL_BITS)'(0), sp_next, rate_q};
    end
  end

endmodule
